[rtl/mbf_pkg.sv]
`timescale 1ns / 1ps
package mbf_pkg;
    localparam int GAIN_W     = 10;
    localparam int RAD_W      = 6;
    localparam int INT_W      = 8;
    localparam int IDX_W      = 3;
    localparam int GAIN_RESET = 300;
    localparam logic [INT_W-1:0] FULL_SCALE = 8'd255;
    localparam int NUM_W      = GAIN_W + 2 * RAD_W;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EVAL = 1'b1
    } t_action;
endpackage

[rtl/mbf_cell.sv]
`timescale 1ns / 1ps
// One ball. Holds its table entry; divides num by d one quotient bit a cycle
// then hands the saturated running sum to the next cell.
module mbf_cell #(
    parameter int COORD_BITS = 11,
    parameter logic [mbf_pkg::IDX_W-1:0] MY_INDEX = '0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [mbf_pkg::IDX_W-1:0]   i_index,
    input  logic [COORD_BITS-1:0]       i_cx,
    input  logic [COORD_BITS-1:0]       i_cy,
    input  logic [mbf_pkg::RAD_W-1:0]   i_rad,
    input  logic [mbf_pkg::GAIN_W-1:0]  i_gain,
    input  logic                        i_start,
    input  logic [COORD_BITS-1:0]       i_px,
    input  logic [COORD_BITS-1:0]       i_py,
    input  logic [mbf_pkg::INT_W-1:0]   i_sum,
    output logic                        o_done,
    output logic [mbf_pkg::INT_W-1:0]   o_sum
);
    import mbf_pkg::*;

    localparam int D_W = 2 * COORD_BITS + 1;
    localparam int Q_W = INT_W + 1;          // quotient bits kept; >255 saturates
    localparam int CNT_W = $clog2(Q_W + 3);
    // wide enough for d shifted by every quotient bit and for num
    localparam int T_W = ((D_W > NUM_W) ? D_W : NUM_W) + Q_W;

    typedef enum logic [1:0] {S_IDLE, S_SQ, S_DIV, S_OUT} t_state;

    logic [COORD_BITS-1:0] r_cx, r_cy;
    logic [RAD_W-1:0]      r_rad;
    t_state                r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [D_W-1:0]        r_d;
    logic [NUM_W-1:0]      r_num;
    logic [INT_W-1:0]      r_sum;
    logic [Q_W-1:0]        r_q;
    logic [T_W-1:0]        r_rem;
    logic                  r_done;
    logic [INT_W-1:0]      r_out;

    logic [COORD_BITS-1:0] dx, dy;
    logic [T_W-1:0]        trial;
    logic [INT_W:0]        add;
    logic [INT_W-1:0]      term;
    logic                  big;

    assign dx = (i_px >= r_cx) ? i_px - r_cx : r_cx - i_px;
    assign dy = (i_py >= r_cy) ? i_py - r_cy : r_cy - i_py;
    // restoring division: quotient bit Q_W-1 down to 0 of num/d
    assign trial = T_W'(r_d) << r_cnt;
    // any quotient bit at Q_W or above means saturation
    assign big = T_W'(r_num) >= (T_W'(r_d) << Q_W);
    assign term = (r_rad == '0) ? '0 :
                  (r_d == '0) ? FULL_SCALE :
                  (r_q[Q_W-1] ? FULL_SCALE : r_q[INT_W-1:0]);
    assign add = {1'b0, r_sum} + {1'b0, term};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_rad <= '0;
            r_state <= S_IDLE; r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_load && i_index == MY_INDEX) begin
                r_cx <= i_cx; r_cy <= i_cy; r_rad <= i_rad;
            end
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_dx <= dx; r_dy <= dy; r_sum <= i_sum;
                    r_num <= NUM_W'(i_gain * r_rad);
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_d <= D_W'(r_dx * r_dx) + D_W'(r_dy * r_dy);
                    r_num <= NUM_W'(r_num * r_rad);
                    r_state <= S_DIV;
                    r_cnt <= CNT_W'(Q_W - 1);
                    r_q <= '0;
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(Q_W - 1)) begin
                        if (big) begin
                            r_q <= '1;
                            r_state <= S_OUT;
                        end else begin
                            r_rem <= T_W'(r_num);
                            r_cnt <= r_cnt - 1'b1;
                            r_q <= '0;
                            r_state <= S_DIV;
                        end
                        if (!big && r_d != '0 && T_W'(r_num) >= trial) begin
                            r_rem <= T_W'(r_num) - trial;
                            r_q[Q_W-1] <= 1'b1;
                        end
                    end else begin
                        if (r_d != '0 && r_rem >= trial) begin
                            r_rem <= r_rem - trial;
                            r_q[r_cnt[$clog2(Q_W)-1:0]] <= 1'b1;
                        end
                        if (r_cnt == '0) r_state <= S_OUT;
                        else r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_OUT: begin
                    r_out <= add[INT_W] ? FULL_SCALE : add[INT_W-1:0];
                    r_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_out;
endmodule

[rtl/metaball_field_intensity.sv]
`timescale 1ns / 1ps
// Each ball's cell takes start, square, 9 restoring division steps and accumulate,
// with the division cut short when the quotient is sure to saturate; the balls' cells work
// one after another, so a result is valid once the last cell has accumulated.
// A new pixel beat is taken only after the result of the last one has been taken by the
// sink; load beats are taken only while no pixel is in flight and no result is pending.
// Reset (synchronous, active low) clears the ball table and sets gain to 300.
module metaball_field_intensity #(
    parameter int BALLS      = 5,
    parameter int COORD_BITS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,   // gain[9:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // ball_index[2:0], ctr_col, ctr_row, radius, pixel_x, pixel_y (lsb up)
    input  logic [(3 + 4 * COORD_BITS + 6 + 7) / 8 * 8 - 1:0] s_axis_tdata,
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // intensity
);
    import mbf_pkg::*;

    localparam int CX_LO = IDX_W;
    localparam int CY_LO = CX_LO + COORD_BITS;
    localparam int RD_LO = CY_LO + COORD_BITS;
    localparam int PX_LO = RD_LO + RAD_W;
    localparam int PY_LO = PX_LO + COORD_BITS;

    logic [GAIN_W-1:0] r_gain;
    logic              r_busy;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic              r_kick;
    logic [BALLS:0]    done;
    logic [INT_W-1:0]  sums [BALLS+1];
    logic              r_ovalid;
    logic [INT_W-1:0]  r_odata;
    logic              acc, load;

    assign s_axis_tready = !r_busy && !r_ovalid;
    assign acc  = s_axis_tvalid && s_axis_tready;
    assign load = acc && (s_axis_tuser == ACT_LOAD);
    assign done[0] = r_kick;
    assign sums[0] = '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_W'(GAIN_RESET);
            r_busy <= 1'b0; r_kick <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_kick <= 1'b0;
            if (i_cfg_we) r_gain <= i_cfg_wdata[GAIN_W-1:0];
            if (acc && s_axis_tuser == ACT_EVAL) begin
                r_px <= s_axis_tdata[PX_LO +: COORD_BITS];
                r_py <= s_axis_tdata[PY_LO +: COORD_BITS];
                r_busy <= 1'b1; r_kick <= 1'b1;
            end
            if (done[BALLS]) begin
                r_ovalid <= 1'b1; r_odata <= sums[BALLS]; r_busy <= 1'b0;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < BALLS; g++) begin : g_cell
        mbf_cell #(.COORD_BITS(COORD_BITS), .MY_INDEX(IDX_W'(g))) u_cell (
            .i_clk, .i_rst_n,
            .i_load (load),
            .i_index(s_axis_tdata[IDX_W-1:0]),
            .i_cx   (s_axis_tdata[CX_LO +: COORD_BITS]),
            .i_cy   (s_axis_tdata[CY_LO +: COORD_BITS]),
            .i_rad  (s_axis_tdata[RD_LO +: RAD_W]),
            .i_gain (r_gain),
            .i_start(done[g]),
            .i_px   (r_px),
            .i_py   (r_py),
            .i_sum  (sums[g]),
            .o_done (done[g+1]),
            .o_sum  (sums[g+1])
        );
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule

[rtl/mbf_checker.sv]
`timescale 1ns / 1ps
module mbf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("pixel beat did not block input");
    a_noin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
endmodule

bind metaball_field_intensity mbf_checker u_chk (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

[tb/tb_metaball_field_intensity.sv]
`timescale 1ns / 1ps
module tb_metaball_field_intensity;
    import mbf_pkg::*;

    localparam int N_BALLS = 5;
    localparam int CB      = 11;
    localparam int TD_W    = (3 + 4 * CB + 6 + 7) / 8 * 8;
    localparam int DRAIN   = N_BALLS * 13 + 20;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [15:0]       i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [TD_W-1:0]   s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [INT_W-1:0]  m_axis_tdata;

    metaball_field_intensity #(.BALLS(N_BALLS), .COORD_BITS(CB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    typedef struct {
        t_action          act;
        logic [IDX_W-1:0] idx;
        logic [CB-1:0]    cx;
        logic [CB-1:0]    cy;
        logic [RAD_W-1:0] rad;
        logic [CB-1:0]    px;
        logic [CB-1:0]    py;
        int               known;   // -1: take the predictor's value
    } t_beat;

    // shadow of the ball table and gain
    logic [CB-1:0]     sh_col [N_BALLS];
    logic [CB-1:0]     sh_row [N_BALLS];
    logic [RAD_W-1:0]  sh_rad [N_BALLS];
    logic [GAIN_W-1:0] sh_gain;

    logic [INT_W-1:0] pending_grey[$];
    int  errors, n_loads, n_pixels, n_checked;
    int  tx_pct, rx_pct, hold_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Timeout at %0t", $time);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [INT_W-1:0] field_grey(logic [CB-1:0] px, logic [CB-1:0] py);
        longint unsigned dx, dy, d, num, q;
        int sum;
        sum = 0;
        for (int b = 0; b < N_BALLS; b++) begin
            if (sh_rad[b] != 0) begin
                dx = (px >= sh_col[b]) ? px - sh_col[b] : sh_col[b] - px;
                dy = (py >= sh_row[b]) ? py - sh_row[b] : sh_row[b] - py;
                d  = dx * dx + dy * dy;
                if (d == 0) begin
                    q = FULL_SCALE;
                end else begin
                    num = longint'(sh_gain) * sh_rad[b] * sh_rad[b];
                    q = num / d;
                end
                sum += (q > FULL_SCALE) ? int'(FULL_SCALE) : int'(q);
                if (sum > FULL_SCALE) sum = FULL_SCALE;
            end
        end
        return sum[INT_W-1:0];
    endfunction

    // receiver: random stalls plus an optional long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_grey.size() == 0) begin
                $display("%0t: unexpected beat, actual %0d", $time, m_axis_tdata);
                errors++;
            end else begin
                if (m_axis_tdata !== pending_grey[0]) begin
                    $display("%0t: intensity expected %0d actual %0d",
                             $time, pending_grey[0], m_axis_tdata);
                    errors++;
                end
                void'(pending_grey.pop_front());
                n_checked++;
            end
        end
    end

    task automatic send(t_beat bt);
        logic [INT_W-1:0] pred;
        while (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= bt.act;
        s_axis_tdata  <= {{(TD_W - 3 - 4 * CB - RAD_W){1'b0}},
                          bt.py, bt.px, bt.rad, bt.cy, bt.cx, bt.idx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (bt.act == ACT_LOAD) begin
            n_loads++;
            if (bt.idx < N_BALLS) begin
                sh_col[bt.idx] = bt.cx;
                sh_row[bt.idx] = bt.cy;
                sh_rad[bt.idx] = bt.rad;
            end
        end else begin
            n_pixels++;
            pred = field_grey(bt.px, bt.py);
            if (bt.known >= 0 && pred != bt.known) begin
                $display("%0t: table row expected %0d predictor %0d", $time, bt.known, pred);
                errors++;
            end
            pending_grey.push_back(pred);
        end
    endtask

    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_grey.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_gain(logic [GAIN_W-1:0] g);
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= {6'd0, g};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sh_gain = g;
    endtask

    function automatic t_beat rand_beat();
        t_beat bt;
        int b;
        bt.act   = ($urandom_range(99) < 35) ? ACT_LOAD : ACT_EVAL;
        bt.idx   = IDX_W'(($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4));
        bt.cx    = CB'($urandom);
        bt.cy    = CB'($urandom);
        bt.rad   = ($urandom_range(7) == 0) ? 6'd0 : RAD_W'($urandom);
        bt.px    = CB'($urandom);
        bt.py    = CB'($urandom);
        bt.known = -1;
        if (bt.act == ACT_LOAD && $urandom_range(1)) begin
            // cluster centres so the fields overlap
            bt.cx = CB'(1000 + $urandom_range(200));
            bt.cy = CB'(1000 + $urandom_range(200));
        end
        if (bt.act == ACT_EVAL && $urandom_range(3) != 0) begin
            b = int'($urandom_range(N_BALLS - 1));
            bt.px = CB'(sh_col[b] + $urandom_range(80) - 40);
            bt.py = CB'(sh_row[b] + $urandom_range(80) - 40);
        end
        return bt;
    endfunction

    t_beat table_rows[$];
    int    tx_tab[5] = '{0, 51, 0, 6, 0};
    int    rx_tab[5] = '{0, 0, 51, 6, 0};

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_LOAD;
        errors = 0; n_loads = 0; n_pixels = 0; n_checked = 0;
        tx_pct = 0; rx_pct = 0; hold_left = 0;
        sh_gain = GAIN_W'(GAIN_RESET);
        for (int b = 0; b < N_BALLS; b++) begin
            sh_col[b] = '0; sh_row[b] = '0; sh_rad[b] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        //              act       idx cx    cy    r   px    py    known
        table_rows = '{
            '{ACT_EVAL, 3'd0, 0,    0,    0,  0,    0,    0},    // empty table
            '{ACT_LOAD, 3'd0, 100,  100,  10, 2047, 2047, -1},
            '{ACT_EVAL, 3'd0, 0,    0,    0,  100,  100,  255},  // ball on the pixel
            '{ACT_EVAL, 3'd7, 2047, 2047, 63, 2047, 2047, -1},   // load fields ignored
            '{ACT_LOAD, 3'd1, 2047, 2047, 63, 0,    0,    -1},
            '{ACT_EVAL, 3'd0, 0,    0,    0,  2047, 2047, 255},
            '{ACT_LOAD, 3'd2, 0,    0,    0,  0,    0,    -1},   // zero radius
            '{ACT_EVAL, 3'd0, 0,    0,    0,  0,    0,    -1},
            '{ACT_LOAD, 3'd5, 50,   50,   63, 0,    0,    -1},   // index out of range
            '{ACT_LOAD, 3'd7, 2047, 2047, 63, 2047, 2047, -1},
            '{ACT_EVAL, 3'd0, 0,    0,    0,  50,   50,   -1},
            '{ACT_EVAL, 3'd0, 0,    0,    0,  110,  100,  255},  // saturates
            '{ACT_LOAD, 3'd3, 500,  500,  1,  0,    0,    -1},
            '{ACT_LOAD, 3'd4, 0,    2047, 63, 0,    0,    -1},
            '{ACT_EVAL, 3'd0, 0,    0,    0,  501,  500,  -1},
            '{ACT_EVAL, 3'd0, 0,    0,    0,  2047, 0,    -1},
            '{ACT_EVAL, 3'd0, 0,    0,    0,  0,    2047, -1},
            '{ACT_EVAL, 3'd0, 0,    0,    0,  1024, 1024, -1}
        };
        foreach (table_rows[k]) send(table_rows[k]);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_gain(GAIN_W'(GAIN_RESET));
                1: set_gain(10'd0);
                2: set_gain(10'd1023);
                3: set_gain(GAIN_W'($urandom));
                default: set_gain(10'd1);
            endcase
            tx_pct = tx_tab[ph];
            rx_pct = rx_tab[ph];
            if (ph == 4) hold_left = 600;   // sink stalls, source keeps pushing
            for (int k = 0; k < 180; k++) send(rand_beat());
        end

        quiesce();
        $display("Covered %0d load beats and %0d pixel beats, %0d intensities checked,",
                 n_loads, n_pixels, n_checked);
        $display("over five gain settings and four idle patterns with a long sink stall.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

[files.f]
rtl/mbf_pkg.sv
rtl/mbf_cell.sv
rtl/metaball_field_intensity.sv
rtl/mbf_checker.sv
tb/tb_metaball_field_intensity.sv
